/* design/lsc_pkg.sv */
// ----------------------------------------------------------------------------
// lsc_pkg: shared constants and types for the line segment clipper
// Coordinate width, outcode bits, configuration register indexes.
// ----------------------------------------------------------------------------
package lsc_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * COORD_BITS;
    localparam int MOVE_LIMIT = 8;
    localparam int MOVE_BITS  = $clog2(MOVE_LIMIT + 1);
    localparam int STEP_BITS  = $clog2(PROD_BITS + 1);
    localparam int CFG_IDX_BITS = 2;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [3:0] t_outcode;

    localparam t_outcode OC_LEFT   = 4'd1;
    localparam t_outcode OC_RIGHT  = 4'd2;
    localparam t_outcode OC_BOTTOM = 4'd4;
    localparam t_outcode OC_TOP    = 4'd8;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WIN_LEFT   = 2'd0,
        CFG_WIN_BOTTOM = 2'd1,
        CFG_WIN_RIGHT  = 2'd2,
        CFG_WIN_TOP    = 2'd3
    } t_cfg_idx;

    localparam t_coord RST_WIN_LEFT   = t_coord'(0);
    localparam t_coord RST_WIN_BOTTOM = t_coord'(0);
    localparam t_coord RST_WIN_RIGHT  = t_coord'(639);
    localparam t_coord RST_WIN_TOP    = t_coord'(479);

endpackage

/* design/lsc_seg_if.sv */
// ----------------------------------------------------------------------------
// lsc_seg_if: segment input channel
// Valid/ready channel carrying the two endpoints of one segment.
// ----------------------------------------------------------------------------
interface lsc_seg_if;
    logic                valid;
    logic                ready;
    lsc_pkg::t_coord     start_x;
    lsc_pkg::t_coord     start_y;
    lsc_pkg::t_coord     end_x;
    lsc_pkg::t_coord     end_y;

    modport source (output valid, output start_x, output start_y,
                    output end_x, output end_y, input ready);
    modport sink   (input valid, input start_x, input start_y,
                    input end_x, input end_y, output ready);
endinterface

/* design/lsc_clip_if.sv */
// ----------------------------------------------------------------------------
// lsc_clip_if: clipped segment output channel
// Valid/ready channel carrying the accept flag and clipped endpoints.
// ----------------------------------------------------------------------------
interface lsc_clip_if;
    logic                valid;
    logic                ready;
    logic                accepted;
    lsc_pkg::t_coord     clip_start_x;
    lsc_pkg::t_coord     clip_start_y;
    lsc_pkg::t_coord     clip_end_x;
    lsc_pkg::t_coord     clip_end_y;

    modport source (output valid, output accepted, output clip_start_x,
                    output clip_start_y, output clip_end_x, output clip_end_y,
                    input ready);
    modport sink   (input valid, input accepted, input clip_start_x,
                    input clip_start_y, input clip_end_x, input clip_end_y,
                    output ready);
endinterface

/* design/line_segment_clipper.sv */
// ----------------------------------------------------------------------------
// line_segment_clipper: Cohen-Sutherland clipping of one segment
// Clips a segment against a window held in four configuration registers.
// ----------------------------------------------------------------------------
// Usage:
//   i_seg  : sink channel, one word per segment (start and end endpoints).
//   o_clip : source channel, one word per segment: accepted flag plus the
//            clipped endpoints, all endpoints zero when rejected.
//   i_cfg_* : write port for win_left, win_bottom, win_right, win_top;
//            write only while no segment is in flight.
// Sequence: a trivial accept or reject goes through the outcode step and the
//   finish step into the output register. Each endpoint move passes through
//   an outcode step, a multiply step, the shared restoring divider (one
//   quotient bit a cycle) and an update step. A well-formed window needs
//   at most four moves; the move limit of eight bounds an inverted window.
// Throughput: one segment at a time; i_seg.ready is high only when idle.
//   A finished word waits in the output register while the next segment is
//   accepted; the block stalls at its last step only if that register is
//   still full.
// Reset: synchronous, active low; clears the sequencer and output valid and
//   loads the default window (0, 0) to (639, 479).
module line_segment_clipper (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    lsc_seg_if.sink                                i_seg,
    lsc_clip_if.source                             o_clip,
    input  logic                                   i_cfg_we,
    input  logic [lsc_pkg::CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  logic [lsc_pkg::COORD_BITS-1:0]         i_cfg_data
);

    localparam int CB = lsc_pkg::COORD_BITS;
    localparam int DB = lsc_pkg::DIFF_BITS;
    localparam int PB = lsc_pkg::PROD_BITS;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_CODE = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_UPD  = 6'b010000,
        ST_FIN  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // window registers
    lsc_pkg::t_coord r_win_l, r_win_b, r_win_r, r_win_t;

    // working endpoints
    lsc_pkg::t_coord r_x1, r_y1, r_x2, r_y2;
    lsc_pkg::t_coord n_x1, n_y1, n_x2, n_y2;

    logic [lsc_pkg::MOVE_BITS-1:0] r_moves, n_moves;
    logic                          r_ok, n_ok;

    // move operands
    logic                   r_neg, n_neg;
    logic                   r_move_end, n_move_end;   // 1: move the end point
    logic                   r_horiz, n_horiz;         // 1: crossing a top/bottom edge
    lsc_pkg::t_coord        r_edge, n_edge;
    logic [CB-1:0]          r_mag_a, n_mag_a, r_mag_b, n_mag_b;
    logic [CB-1:0]          r_div, n_div;

    // divider
    logic [PB-1:0]                 r_quo, n_quo;
    logic [CB-1:0]                 r_rem, n_rem;
    logic [lsc_pkg::STEP_BITS-1:0] r_step, n_step;

    // output register
    logic            r_out_valid, n_out_valid;
    logic            r_out_acc, n_out_acc;
    lsc_pkg::t_coord r_out_sx, r_out_sy, r_out_ex, r_out_ey;
    lsc_pkg::t_coord n_out_sx, n_out_sy, n_out_ex, n_out_ey;

    function automatic lsc_pkg::t_outcode region(
        input lsc_pkg::t_coord x, input lsc_pkg::t_coord y,
        input lsc_pkg::t_coord l, input lsc_pkg::t_coord b,
        input lsc_pkg::t_coord r, input lsc_pkg::t_coord t);
        lsc_pkg::t_outcode c;
        c = '0;
        if (y > t) c = c | lsc_pkg::OC_TOP;
        if (y < b) c = c | lsc_pkg::OC_BOTTOM;
        if (x < l) c = c | lsc_pkg::OC_LEFT;
        if (x > r) c = c | lsc_pkg::OC_RIGHT;
        return c;
    endfunction

    function automatic logic [CB-1:0] mag(input logic signed [DB-1:0] v);
        logic signed [DB-1:0] n;
        n = -v;
        return v[DB-1] ? n[CB-1:0] : v[CB-1:0];
    endfunction

    lsc_pkg::t_outcode c1, c2, sel;
    logic signed [DB-1:0] d_a, d_b, d_c;
    lsc_pkg::t_coord      edge_v;
    logic                 horiz_v;
    logic [CB:0]          trial;
    logic [CB:0]          trial_sub;
    logic signed [DB-1:0] q_signed;
    logic signed [DB-1:0] new_coord;
    logic [CB-1:0]        q_mag;

    assign c1  = region(r_x1, r_y1, r_win_l, r_win_b, r_win_r, r_win_t);
    assign c2  = region(r_x2, r_y2, r_win_l, r_win_b, r_win_r, r_win_t);
    assign sel = (c1 != '0) ? c1 : c2;

    // pick the edge and build the three differences of the crossing formula
    always_comb begin
        horiz_v = (sel & (lsc_pkg::OC_TOP | lsc_pkg::OC_BOTTOM)) != '0;
        if (horiz_v) begin
            edge_v = ((sel & lsc_pkg::OC_TOP) != '0) ? r_win_t : r_win_b;
            d_a = DB'(edge_v) - DB'(r_y1);
            d_b = DB'(r_x2) - DB'(r_x1);
            d_c = DB'(r_y2) - DB'(r_y1);
        end else begin
            edge_v = ((sel & lsc_pkg::OC_LEFT) != '0) ? r_win_l : r_win_r;
            d_a = DB'(edge_v) - DB'(r_x1);
            d_b = DB'(r_y2) - DB'(r_y1);
            d_c = DB'(r_x2) - DB'(r_x1);
        end
    end

    assign trial     = {r_rem, r_quo[PB-1]};
    assign trial_sub = trial - {1'b0, r_div};
    assign q_mag     = r_quo[CB-1:0];
    assign q_signed  = r_neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    assign new_coord = (r_horiz ? DB'(r_x1) : DB'(r_y1)) + q_signed;

    assign i_seg.ready = (r_state == ST_IDLE);

    always_comb begin
        n_state    = r_state;
        n_x1 = r_x1; n_y1 = r_y1; n_x2 = r_x2; n_y2 = r_y2;
        n_moves    = r_moves;
        n_ok       = r_ok;
        n_neg      = r_neg;
        n_move_end = r_move_end;
        n_horiz    = r_horiz;
        n_edge     = r_edge;
        n_mag_a    = r_mag_a;
        n_mag_b    = r_mag_b;
        n_div      = r_div;
        n_quo      = r_quo;
        n_rem      = r_rem;
        n_step     = r_step;
        n_out_valid = r_out_valid && !o_clip.ready;
        n_out_acc  = r_out_acc;
        n_out_sx = r_out_sx; n_out_sy = r_out_sy;
        n_out_ex = r_out_ex; n_out_ey = r_out_ey;
        case (r_state)
            ST_IDLE: begin
                if (i_seg.valid) begin
                    n_x1 = i_seg.start_x; n_y1 = i_seg.start_y;
                    n_x2 = i_seg.end_x;   n_y2 = i_seg.end_y;
                    n_moves = '0;
                    n_state = ST_CODE;
                end
            end
            ST_CODE: begin
                if (c1 == '0 && c2 == '0) begin
                    n_ok    = 1'b1;
                    n_state = ST_FIN;
                end else if ((c1 & c2) != '0 ||
                             r_moves == lsc_pkg::MOVE_BITS'(lsc_pkg::MOVE_LIMIT)) begin
                    n_ok    = 1'b0;
                    n_state = ST_FIN;
                end else begin
                    n_neg      = d_a[DB-1] ^ d_b[DB-1] ^ d_c[DB-1];
                    n_move_end = (c1 == '0);
                    n_horiz    = horiz_v;
                    n_edge     = edge_v;
                    n_mag_a    = mag(d_a);
                    n_mag_b    = mag(d_b);
                    n_div      = mag(d_c);
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                n_quo   = PB'(r_mag_a) * PB'(r_mag_b);
                n_rem   = '0;
                n_step  = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                // one restoring step: shift in the next dividend bit
                if (!trial_sub[CB]) begin
                    n_rem = trial_sub[CB-1:0];
                    n_quo = {r_quo[PB-2:0], 1'b1};
                end else begin
                    n_rem = trial[CB-1:0];
                    n_quo = {r_quo[PB-2:0], 1'b0};
                end
                n_step = r_step + 1'b1;
                if (r_step == lsc_pkg::STEP_BITS'(PB - 1)) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                if (r_move_end) begin
                    n_x2 = r_horiz ? lsc_pkg::t_coord'(new_coord[CB-1:0]) : r_edge;
                    n_y2 = r_horiz ? r_edge : lsc_pkg::t_coord'(new_coord[CB-1:0]);
                end else begin
                    n_x1 = r_horiz ? lsc_pkg::t_coord'(new_coord[CB-1:0]) : r_edge;
                    n_y1 = r_horiz ? r_edge : lsc_pkg::t_coord'(new_coord[CB-1:0]);
                end
                n_moves = r_moves + 1'b1;
                n_state = ST_CODE;
            end
            ST_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || o_clip.ready) begin
                    n_out_valid = 1'b1;
                    n_out_acc   = r_ok;
                    n_out_sx = r_ok ? r_x1 : '0;
                    n_out_sy = r_ok ? r_y1 : '0;
                    n_out_ex = r_ok ? r_x2 : '0;
                    n_out_ey = r_ok ? r_y2 : '0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_moves     <= '0;
            r_win_l     <= lsc_pkg::RST_WIN_LEFT;
            r_win_b     <= lsc_pkg::RST_WIN_BOTTOM;
            r_win_r     <= lsc_pkg::RST_WIN_RIGHT;
            r_win_t     <= lsc_pkg::RST_WIN_TOP;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_moves     <= n_moves;
            if (i_cfg_we) begin
                case (lsc_pkg::t_cfg_idx'(i_cfg_idx))
                    lsc_pkg::CFG_WIN_LEFT:   r_win_l <= i_cfg_data;
                    lsc_pkg::CFG_WIN_BOTTOM: r_win_b <= i_cfg_data;
                    lsc_pkg::CFG_WIN_RIGHT:  r_win_r <= i_cfg_data;
                    lsc_pkg::CFG_WIN_TOP:    r_win_t <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x1 <= n_x1; r_y1 <= n_y1; r_x2 <= n_x2; r_y2 <= n_y2;
        r_ok       <= n_ok;
        r_neg      <= n_neg;
        r_move_end <= n_move_end;
        r_horiz    <= n_horiz;
        r_edge     <= n_edge;
        r_mag_a    <= n_mag_a;
        r_mag_b    <= n_mag_b;
        r_div      <= n_div;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_step     <= n_step;
        r_out_acc  <= n_out_acc;
        r_out_sx <= n_out_sx; r_out_sy <= n_out_sy;
        r_out_ex <= n_out_ex; r_out_ey <= n_out_ey;
    end

    assign o_clip.valid        = r_out_valid;
    assign o_clip.accepted     = r_out_acc;
    assign o_clip.clip_start_x = r_out_sx;
    assign o_clip.clip_start_y = r_out_sy;
    assign o_clip.clip_end_x   = r_out_ex;
    assign o_clip.clip_end_y   = r_out_ey;

`ifndef NO_ASSERTIONS
    a_not_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !i_seg.ready)
        else $error("segment input ready while busy");
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_acc) |-> (r_out_sx == '0 && r_out_sy == '0 &&
                                         r_out_ex == '0 && r_out_ey == '0))
        else $error("rejected segment carries nonzero endpoints");
    a_move_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_moves <= lsc_pkg::MOVE_BITS'(lsc_pkg::MOVE_LIMIT)))
        else $error("move counter past limit");
    a_div_to_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_step == lsc_pkg::STEP_BITS'(PB - 1)) |=>
        (r_state == ST_UPD))
        else $error("divider did not hand over to update");
`endif

endmodule
